// ===== rtl/abc_pkg.sv =====
package abc_pkg;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_UPDATE = 2'd1;
  localparam logic [1:0] OP_INSERT = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_MISS   = 2'd1;
  localparam logic [1:0] ST_REJECT = 2'd2;

  localparam logic [1:0] MODE_IDLE        = 2'd0;
  localparam logic [1:0] MODE_WRITE       = 2'd1;
  localparam logic [1:0] MODE_DROP_MISS   = 2'd2;
  localparam logic [1:0] MODE_DROP_REJECT = 2'd3;

  localparam logic CFG_ENABLE = 1'b0;
  localparam logic CFG_ACTIVE = 1'b1;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [3:0]  disk_id;
    logic [7:0]  block_id;
    logic [63:0] data_word;
    logic        data_last;
    logic        range_ok;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] read_word;
    logic        result_last;
    logic [31:0] hit_count;
    logic [31:0] query_count;
  } result_t;

  typedef struct packed {
    logic [3:0]  disk_id;
    logic [7:0]  block_id;
    logic [31:0] stamp;
  } tag_t;

endpackage

// ===== rtl/abc_fifo.sv =====
module abc_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wptr_r;
  logic             rptr_r;
  logic [1:0]       cnt_r;
  logic             do_wr;
  logic             do_rd;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (do_wr) wptr_r <= !wptr_r;
      if (do_rd) rptr_r <= !rptr_r;
      if (do_wr && !do_rd) cnt_r <= cnt_r + 2'd1;
      else if (do_rd && !do_wr) cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wptr_r] <= wr_data;
  end

endmodule

// ===== rtl/abc_front.sv =====
module abc_front
  import abc_pkg::*;
#(
  parameter int DISK_COUNT      = 16,
  parameter int BLOCKS_PER_DISK = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_opcode,
  input  logic [3:0]  in_disk_id,
  input  logic [7:0]  in_block_id,
  input  logic [63:0] in_data_word,
  input  logic        in_data_last,
  input  logic        item_pop,
  output item_t       item,
  output logic        item_empty
);

  item_t                  wr_item;
  logic [$bits(item_t)-1:0] rd_bits;

  always_comb begin
    wr_item.opcode    = in_opcode;
    wr_item.disk_id   = in_disk_id;
    wr_item.block_id  = in_block_id;
    wr_item.data_word = in_data_word;
    wr_item.data_last = in_data_last;
    wr_item.range_ok  = (32'(in_disk_id) < DISK_COUNT) &&
                        (32'(in_block_id) < BLOCKS_PER_DISK);
  end

  abc_fifo #(.WIDTH($bits(item_t))) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_data (wr_item),
    .full    (full),
    .rd_en   (item_pop),
    .rd_data (rd_bits),
    .empty   (item_empty)
  );

  assign item = item_t'(rd_bits);

endmodule

// ===== rtl/abc_back.sv =====
module abc_back
  import abc_pkg::*;
#(
  parameter int ENTRY_COUNT = 64,
  parameter int BLOCK_WORDS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  item_t      item,
  input  logic       item_empty,
  output logic       item_pop,
  output result_t    res,
  output logic       res_push,
  input  logic       res_full,
  input  logic       cfg_wr,
  input  logic       cfg_sel,
  input  logic [6:0] cfg_val
);

  localparam int EW = $clog2(ENTRY_COUNT);
  localparam int WB = $clog2(BLOCK_WORDS + 1);
  localparam int AW = $clog2(ENTRY_COUNT * BLOCK_WORDS);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SCAN    = 3'd1;
  localparam logic [2:0] S_DECIDE  = 3'd2;
  localparam logic [2:0] S_BEAT    = 3'd3;
  localparam logic [2:0] S_RD_REQ  = 3'd4;
  localparam logic [2:0] S_RD_PUSH = 3'd5;

  logic [2:0]             state_r, state_nxt;
  item_t                  item_r, item_nxt;
  logic [1:0]             mode_r, mode_nxt;
  logic [WB-1:0]          beat_r, beat_nxt;
  logic [WB-1:0]          rd_cnt_r, rd_cnt_nxt;
  logic [EW-1:0]          target_r, target_nxt;
  logic [ENTRY_COUNT-1:0] valid_r, valid_nxt;
  logic [31:0]            stamp_r, stamp_nxt;
  logic [31:0]            hits_r, hits_nxt;
  logic [31:0]            queries_r, queries_nxt;
  logic                   enable_r, enable_nxt;
  logic [6:0]             active_r, active_nxt;
  logic [EW:0]            scan_idx_r, scan_idx_nxt;
  logic                   cmp_v_r, cmp_v_nxt;
  logic [EW-1:0]          cmp_idx_r, cmp_idx_nxt;
  logic                   found_r, found_nxt;
  logic [EW-1:0]          fidx_r, fidx_nxt;
  logic                   inv_found_r, inv_found_nxt;
  logic [EW-1:0]          iidx_r, iidx_nxt;
  logic [31:0]            max_r, max_nxt;
  logic [EW-1:0]          midx_r, midx_nxt;

  tag_t                   tag_mem [ENTRY_COUNT];
  tag_t                   tag_rd_r;
  logic                   tag_we;
  logic [EW-1:0]          tag_waddr;
  tag_t                   tag_wdata;
  logic [EW-1:0]          tag_raddr;

  logic [63:0]            blk_mem [ENTRY_COUNT * BLOCK_WORDS];
  logic [63:0]            blk_rd_r;
  logic                   blk_we;
  logic [AW-1:0]          blk_waddr;
  logic [AW-1:0]          blk_raddr;

  logic [EW:0]            live_n;
  logic                   key_ok;
  logic                   close;
  logic [EW-1:0]          victim;

  always_comb begin
    if (active_r < 7'd2) live_n = (EW+1)'(2);
    else if (32'(active_r) > ENTRY_COUNT) live_n = (EW+1)'(ENTRY_COUNT);
    else live_n = (EW+1)'(active_r);
  end

  assign key_ok    = enable_r && item.range_ok;
  assign tag_raddr = scan_idx_r[EW-1:0];
  assign blk_raddr = AW'(target_r) * AW'(BLOCK_WORDS) + AW'(rd_cnt_r);
  assign blk_waddr = AW'(target_r) * AW'(BLOCK_WORDS) + AW'(beat_r);
  assign close     = item_r.data_last || ((beat_r + WB'(1)) >= WB'(BLOCK_WORDS));
  assign victim    = inv_found_r ? iidx_r : midx_r;

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    mode_nxt      = mode_r;
    beat_nxt      = beat_r;
    rd_cnt_nxt    = rd_cnt_r;
    target_nxt    = target_r;
    valid_nxt     = valid_r;
    stamp_nxt     = stamp_r;
    hits_nxt      = hits_r;
    queries_nxt   = queries_r;
    enable_nxt    = enable_r;
    active_nxt    = active_r;
    scan_idx_nxt  = scan_idx_r;
    cmp_v_nxt     = 1'b0;
    cmp_idx_nxt   = cmp_idx_r;
    found_nxt     = found_r;
    fidx_nxt      = fidx_r;
    inv_found_nxt = inv_found_r;
    iidx_nxt      = iidx_r;
    max_nxt       = max_r;
    midx_nxt      = midx_r;
    item_pop      = 1'b0;
    res_push      = 1'b0;
    res.status      = ST_OK;
    res.read_word   = 64'd0;
    res.result_last = 1'b1;
    res.hit_count   = hits_r;
    res.query_count = queries_r;
    tag_we        = 1'b0;
    tag_waddr     = fidx_r;
    tag_wdata.disk_id  = item_r.disk_id;
    tag_wdata.block_id = item_r.block_id;
    tag_wdata.stamp    = stamp_r + 32'd1;
    blk_we        = 1'b0;

    if (cmp_v_r) begin
      if (valid_r[cmp_idx_r] && tag_rd_r.disk_id == item_r.disk_id &&
          tag_rd_r.block_id == item_r.block_id && !found_r) begin
        found_nxt = 1'b1;
        fidx_nxt  = cmp_idx_r;
      end
      if (!valid_r[cmp_idx_r] && !inv_found_r) begin
        inv_found_nxt = 1'b1;
        iidx_nxt      = cmp_idx_r;
      end
      if (cmp_idx_r == '0 || tag_rd_r.stamp > max_r) begin
        max_nxt  = tag_rd_r.stamp;
        midx_nxt = cmp_idx_r;
      end
    end

    case (state_r)
      S_IDLE: begin
        if (!item_empty && !res_full) begin
          item_pop      = 1'b1;
          item_nxt      = item;
          scan_idx_nxt  = '0;
          found_nxt     = 1'b0;
          inv_found_nxt = 1'b0;
          if (mode_r != MODE_IDLE) begin
            state_nxt = S_BEAT;
          end else begin
            case (item.opcode)
              OP_LOOKUP: begin
                if (!key_ok) begin
                  res_push   = 1'b1;
                  res.status = ST_REJECT;
                end else begin
                  queries_nxt = queries_r + 32'd1;
                  state_nxt   = S_SCAN;
                end
              end
              OP_UPDATE, OP_INSERT: begin
                beat_nxt   = '0;
                target_nxt = '0;
                if (!key_ok) begin
                  mode_nxt  = MODE_DROP_REJECT;
                  state_nxt = S_BEAT;
                end else begin
                  state_nxt = S_SCAN;
                end
              end
              default: begin
                res_push   = 1'b1;
                res.status = ST_REJECT;
              end
            endcase
          end
        end
      end
      S_SCAN: begin
        if (scan_idx_r < live_n) begin
          cmp_v_nxt    = 1'b1;
          cmp_idx_nxt  = scan_idx_r[EW-1:0];
          scan_idx_nxt = scan_idx_r + (EW+1)'(1);
        end else if (!cmp_v_r) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        case (item_r.opcode)
          OP_LOOKUP: begin
            if (found_r) begin
              hits_nxt   = hits_r + 32'd1;
              stamp_nxt  = stamp_r + 32'd1;
              tag_we     = 1'b1;
              target_nxt = fidx_r;
              rd_cnt_nxt = '0;
              state_nxt  = S_RD_REQ;
            end else begin
              res_push   = 1'b1;
              res.status = ST_MISS;
              state_nxt  = S_IDLE;
            end
          end
          OP_UPDATE: begin
            if (found_r) begin
              target_nxt = fidx_r;
              mode_nxt   = MODE_WRITE;
              stamp_nxt  = stamp_r + 32'd1;
              tag_we     = 1'b1;
            end else begin
              mode_nxt = MODE_DROP_MISS;
            end
            state_nxt = S_BEAT;
          end
          OP_INSERT: begin
            if (found_r) begin
              mode_nxt = MODE_DROP_REJECT;
            end else begin
              target_nxt        = victim;
              valid_nxt[victim] = 1'b1;
              tag_waddr         = victim;
              tag_we            = 1'b1;
              stamp_nxt         = stamp_r + 32'd1;
              mode_nxt          = MODE_WRITE;
            end
            state_nxt = S_BEAT;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_BEAT: begin
        blk_we   = (mode_r == MODE_WRITE);
        beat_nxt = beat_r + WB'(1);
        if (close) begin
          res_push = 1'b1;
          case (mode_r)
            MODE_WRITE:     res.status = ST_OK;
            MODE_DROP_MISS: res.status = ST_MISS;
            default:        res.status = ST_REJECT;
          endcase
          mode_nxt = MODE_IDLE;
          beat_nxt = '0;
        end
        state_nxt = S_IDLE;
      end
      S_RD_REQ: begin
        state_nxt = S_RD_PUSH;
      end
      S_RD_PUSH: begin
        if (!res_full) begin
          res_push        = 1'b1;
          res.read_word   = blk_rd_r;
          res.result_last = (rd_cnt_r == WB'(BLOCK_WORDS - 1));
          rd_cnt_nxt      = rd_cnt_r + WB'(1);
          state_nxt       = res.result_last ? S_IDLE : S_RD_REQ;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (cfg_wr) begin
      if (cfg_sel == CFG_ENABLE) begin
        enable_nxt = cfg_val[0];
        valid_nxt  = '0;
        stamp_nxt  = 32'd0;
        if (mode_r != MODE_IDLE) mode_nxt = MODE_DROP_REJECT;
      end else begin
        active_nxt = cfg_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= MODE_IDLE;
      beat_r      <= '0;
      rd_cnt_r    <= '0;
      target_r    <= '0;
      valid_r     <= '0;
      stamp_r     <= 32'd0;
      hits_r      <= 32'd0;
      queries_r   <= 32'd0;
      enable_r    <= 1'b0;
      active_r    <= 7'd64;
      scan_idx_r  <= '0;
      cmp_v_r     <= 1'b0;
      found_r     <= 1'b0;
      inv_found_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      beat_r      <= beat_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      target_r    <= target_nxt;
      valid_r     <= valid_nxt;
      stamp_r     <= stamp_nxt;
      hits_r      <= hits_nxt;
      queries_r   <= queries_nxt;
      enable_r    <= enable_nxt;
      active_r    <= active_nxt;
      scan_idx_r  <= scan_idx_nxt;
      cmp_v_r     <= cmp_v_nxt;
      found_r     <= found_nxt;
      inv_found_r <= inv_found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r    <= item_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    fidx_r    <= fidx_nxt;
    iidx_r    <= iidx_nxt;
    max_r     <= max_nxt;
    midx_r    <= midx_nxt;
  end

  always_ff @(posedge clk) begin
    if (tag_we) tag_mem[tag_waddr] <= tag_wdata;
    tag_rd_r <= tag_mem[tag_raddr];
  end

  always_ff @(posedge clk) begin
    if (blk_we) blk_mem[blk_waddr] <= item_r.data_word;
    blk_rd_r <= blk_mem[blk_raddr];
  end

endmodule

// ===== rtl/assoc_block_cache_mru.sv =====
// Channel | Direction | Handshake            | Word
// input   | in        | push / full          | opcode, key, data beat, last flag
// result  | out       | pop / empty          | status, read word, last flag, counters
// config  | in        | cfg_valid/cfg_ready  | register index and value
// A lookup scans the tag memory one entry per cycle over the active entries, as does the
// first beat of a write run. A hit then streams each word through a read request and read
// push, holding while the result queue is full. Later beats pass the idle and beat states.
// Reset is synchronous; tag and block memories are not cleared, valid bits are.
// Two-entry queues on input and result sides let either side stall independently.
module assoc_block_cache_mru
  import abc_pkg::*;
#(
  parameter int ENTRY_COUNT     = 64,
  parameter int BLOCK_WORDS     = 32,
  parameter int DISK_COUNT      = 16,
  parameter int BLOCKS_PER_DISK = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_opcode,
  input  logic [3:0]  in_disk_id,
  input  logic [7:0]  in_block_id,
  input  logic [63:0] in_data_word,
  input  logic        in_data_last,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  out_status,
  output logic [63:0] out_read_word,
  output logic        out_result_last,
  output logic [31:0] out_hit_count,
  output logic [31:0] out_query_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data
);

  item_t                      item;
  logic                       item_empty;
  logic                       item_pop;
  result_t                    res;
  logic                       res_push;
  logic                       res_full;
  logic [$bits(result_t)-1:0] out_bits;
  result_t                    out_res;

  assign cfg_ready = 1'b1;

  abc_front #(
    .DISK_COUNT      (DISK_COUNT),
    .BLOCKS_PER_DISK (BLOCKS_PER_DISK)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_opcode    (in_opcode),
    .in_disk_id   (in_disk_id),
    .in_block_id  (in_block_id),
    .in_data_word (in_data_word),
    .in_data_last (in_data_last),
    .item_pop     (item_pop),
    .item         (item),
    .item_empty   (item_empty)
  );

  abc_back #(
    .ENTRY_COUNT (ENTRY_COUNT),
    .BLOCK_WORDS (BLOCK_WORDS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (item),
    .item_empty (item_empty),
    .item_pop   (item_pop),
    .res        (res),
    .res_push   (res_push),
    .res_full   (res_full),
    .cfg_wr     (cfg_valid && cfg_ready),
    .cfg_sel    (cfg_index),
    .cfg_val    (cfg_data)
  );

  abc_fifo #(.WIDTH($bits(result_t))) u_outq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_data (res),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (out_bits),
    .empty   (empty)
  );

  assign out_res         = result_t'(out_bits);
  assign out_status      = out_res.status;
  assign out_read_word   = out_res.read_word;
  assign out_result_last = out_res.result_last;
  assign out_hit_count   = out_res.hit_count;
  assign out_query_count = out_res.query_count;

endmodule
